// ===== hw/rtl/keypad_led_feedback_sequencer_defines.svh =====
// Assertion macros for the keypad LED feedback sequencer.
`ifndef KEYPAD_LED_FEEDBACK_SEQUENCER_DEFINES_SVH
`define KEYPAD_LED_FEEDBACK_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KLFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define KLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/klfs_pkg.sv =====
// Shared types and constants of the keypad LED feedback sequencer.
`default_nettype none
package klfs_pkg;

  localparam int TIME_WIDTH    = 32;
  localparam int HOLD_WIDTH    = 10;
  localparam int DELAY_WIDTH   = 22;
  localparam int COLOR_WIDTH   = 24;
  localparam int LEVEL_WIDTH   = 8;
  localparam int BLINK_PERIOD  = 200;
  localparam int BLINK_PULSE   = 50;
  localparam int PHASE_WIDTH   = $clog2(BLINK_PERIOD);
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic [HOLD_WIDTH-1:0] HOLD_SHORT = HOLD_WIDTH'(200);
  localparam logic [HOLD_WIDTH-1:0] HOLD_LONG  = HOLD_WIDTH'(1000);

  localparam logic [PHASE_WIDTH-1:0] PHASE_LAST  = PHASE_WIDTH'(BLINK_PERIOD - 1);
  localparam logic [PHASE_WIDTH-1:0] PHASE_PULSE = PHASE_WIDTH'(BLINK_PULSE);

  localparam logic [COLOR_WIDTH-1:0] COLOR_BLACK  = 24'h000000;
  localparam logic [COLOR_WIDTH-1:0] COLOR_BLUE   = 24'h0000FF;
  localparam logic [COLOR_WIDTH-1:0] COLOR_GREEN  = 24'h00FF00;
  localparam logic [COLOR_WIDTH-1:0] COLOR_ORANGE = 24'hBB2200;
  localparam logic [COLOR_WIDTH-1:0] COLOR_RED    = 24'hFF0000;
  localparam logic [COLOR_WIDTH-1:0] COLOR_WHITE  = 24'hFFFFFF;

  localparam logic [LEVEL_WIDTH-1:0] LEVEL_OFF  = 8'h00;
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_HIGH = 8'hFF;
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_MED  = 8'h7F;
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_LOW  = 8'h3F;

  localparam logic [DELAY_WIDTH-1:0] DELAY_RESET = DELAY_WIDTH'(10000);

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_FEEDBACK = 3'd1,
    KIND_BL_ON    = 3'd2,
    KIND_BL_OFF   = 3'd3,
    KIND_INIT     = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    FB_OFF       = 4'd0,
    FB_KEYPRESS  = 4'd1,
    FB_OK        = 4'd2,
    FB_ACTION_OK = 4'd3,
    FB_NOT_FOUND = 4'd4,
    FB_FAILED    = 4'd5,
    FB_UNKNOWN   = 4'd6,
    FB_PAUSE_EXC = 4'd7,
    FB_DELETED   = 4'd8,
    FB_WAIT      = 4'd9,
    FB_BUTTON    = 4'd10
  } fb_e;

  typedef enum logic [2:0] {
    LVL_MODE_HIGH = 3'd0,
    LVL_MODE_MED  = 3'd1,
    LVL_MODE_LOW  = 3'd2,
    LVL_MODE_BUS  = 3'd3,
    LVL_MODE_DARK = 3'd4
  } lvl_mode_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_FB_ENABLE = 2'd0,
    REG_BL_ALWAYS = 2'd1,
    REG_BL_DELAY  = 2'd2,
    REG_BL_MODE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                   feedback_led_enable;
    logic                   backlight_always_on;
    logic [DELAY_WIDTH-1:0] backlight_delay_ms;
    logic [2:0]             backlight_level_mode;
  } cfg_t;

  // Time as seen by the transaction being processed.
  typedef struct packed {
    logic [TIME_WIDTH-1:0]  ms;
    logic [PHASE_WIDTH-1:0] ms_mod;
  } now_t;

endpackage
`default_nettype wire

// ===== hw/rtl/keypad_led_feedback_sequencer.sv =====
// Path: input register, one pass of logic, then the result register.
// Throughput: one transaction per cycle while the output is not stalled.
// The input side stalls only while the result register holds an untaken result.
// Reset: asynchronous, active low; clears all timers, the LED and backlight state,
// the millisecond counter, and loads the register defaults.
`default_nettype none
`include "keypad_led_feedback_sequencer_defines.svh"
module keypad_led_feedback_sequencer (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [2:0]                            kind_i,
  input  wire logic [3:0]                            feedback_type_i,
  input  wire logic [klfs_pkg::LEVEL_WIDTH-1:0]      bus_intensity_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic                                       info_led_write_o,
  output logic [klfs_pkg::COLOR_WIDTH-1:0]           info_led_color_o,
  output logic                                       backlight_write_o,
  output logic [klfs_pkg::LEVEL_WIDTH-1:0]           backlight_level_o,
  output logic                                       backlight_is_on_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [klfs_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  wire logic [klfs_pkg::DELAY_WIDTH-1:0]      cfg_wdata_i
);

  klfs_pkg::cfg_t cfg;
  klfs_pkg::now_t now;

  logic                             s1_valid_q, s1_valid_d;
  logic [2:0]                       s1_kind_q;
  logic [3:0]                       s1_type_q;
  logic [klfs_pkg::LEVEL_WIDTH-1:0] s1_bus_q;
  logic                             out_valid_q, out_valid_d;
  logic                             advance, fire, in_accept;

  logic                             led_wr;
  logic [klfs_pkg::COLOR_WIDTH-1:0] led_color;
  logic                             bl_wr;
  logic [klfs_pkg::LEVEL_WIDTH-1:0] bl_level;
  logic                             bl_on;

  logic                             out_led_wr_q;
  logic [klfs_pkg::COLOR_WIDTH-1:0] out_led_color_q;
  logic                             out_bl_wr_q;
  logic [klfs_pkg::LEVEL_WIDTH-1:0] out_bl_level_q;
  logic                             out_bl_on_q;

  // Handshake: move the input stage when the result register is empty or its result is taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = in_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q <= kind_i;
      s1_type_q <= feedback_type_i;
      s1_bus_q  <= bus_intensity_i;
    end
  end

  klfs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  klfs_time u_time (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .kind_i (s1_kind_q),
    .now_o  (now)
  );

  klfs_led u_led (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (fire),
    .kind_i          (s1_kind_q),
    .feedback_type_i (s1_type_q),
    .enable_i        (cfg.feedback_led_enable),
    .now_i           (now),
    .led_wr_o        (led_wr),
    .led_color_o     (led_color)
  );

  klfs_bl u_bl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (fire),
    .kind_i          (s1_kind_q),
    .bus_intensity_i (s1_bus_q),
    .cfg_i           (cfg),
    .now_i           (now),
    .bl_wr_o         (bl_wr),
    .bl_level_o      (bl_level),
    .bl_on_o         (bl_on)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_led_wr_q    <= led_wr;
      out_led_color_q <= led_color;
      out_bl_wr_q     <= bl_wr;
      out_bl_level_q  <= bl_level;
      out_bl_on_q     <= bl_on;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign info_led_write_o  = out_led_wr_q;
  assign info_led_color_o  = out_led_color_q;
  assign backlight_write_o = out_bl_wr_q;
  assign backlight_level_o = out_bl_level_q;
  assign backlight_is_on_o = out_bl_on_q;

  `KLFS_ASSERT_NOW(a_stall_only_when_blocked, in_stall_o, out_valid_o && out_stall_i, "input stalled while result register free")
  `KLFS_ASSERT_NEXT(a_stage_moves, s1_valid_q && !out_valid_q, out_valid_o, "pending transaction did not reach the result register")
  `KLFS_ASSERT_NOW(a_led_black_no_write, out_valid_o && !info_led_write_o, info_led_color_o == klfs_pkg::COLOR_BLACK, "LED colour set without a write")
  `KLFS_ASSERT_NOW(a_bl_off_level_zero, out_valid_o && backlight_write_o && !backlight_is_on_o, backlight_level_o == klfs_pkg::LEVEL_OFF, "backlight off with a nonzero level")

endmodule
`default_nettype wire

// ===== hw/rtl/klfs_cfg.sv =====
// Configuration registers of the keypad LED feedback sequencer.
`default_nettype none
module klfs_cfg (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       cfg_we_i,
  input  wire logic [klfs_pkg::CFG_IDX_WIDTH-1:0]         cfg_idx_i,
  input  wire logic [klfs_pkg::DELAY_WIDTH-1:0]           cfg_wdata_i,
  output klfs_pkg::cfg_t                                  cfg_o
);

  klfs_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        klfs_pkg::REG_FB_ENABLE: cfg_d.feedback_led_enable  = cfg_wdata_i[0];
        klfs_pkg::REG_BL_ALWAYS: cfg_d.backlight_always_on  = cfg_wdata_i[0];
        klfs_pkg::REG_BL_DELAY:  cfg_d.backlight_delay_ms   = cfg_wdata_i;
        klfs_pkg::REG_BL_MODE:   cfg_d.backlight_level_mode = cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.feedback_led_enable  <= 1'b1;
      cfg_q.backlight_always_on  <= 1'b0;
      cfg_q.backlight_delay_ms   <= klfs_pkg::DELAY_RESET;
      cfg_q.backlight_level_mode <= klfs_pkg::LVL_MODE_HIGH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/klfs_time.sv =====
// Millisecond counter with a running count modulo the blink period.
`default_nettype none
module klfs_time (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [2:0]  kind_i,
  output klfs_pkg::now_t   now_o
);

  logic [klfs_pkg::TIME_WIDTH-1:0]  ms_q, ms_d, ms_inc;
  logic [klfs_pkg::PHASE_WIDTH-1:0] mod_q, mod_d, mod_inc;
  logic                             tick;

  assign tick = step_i && (kind_i == klfs_pkg::KIND_TICK);

  // Advance the counter; the modulo restarts after the last phase and when the counter wraps
  always_comb begin
    ms_inc  = ms_q + klfs_pkg::TIME_WIDTH'(1);
    if (ms_inc == '0) begin
      mod_inc = '0;
    end else if (mod_q == klfs_pkg::PHASE_LAST) begin
      mod_inc = '0;
    end else begin
      mod_inc = mod_q + klfs_pkg::PHASE_WIDTH'(1);
    end
    ms_d  = tick ? ms_inc  : ms_q;
    mod_d = tick ? mod_inc : mod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q  <= '0;
      mod_q <= '0;
    end else begin
      ms_q  <= ms_d;
      mod_q <= mod_d;
    end
  end

  // A tick sees the advanced time
  assign now_o.ms     = ms_d;
  assign now_o.ms_mod = mod_d;

endmodule
`default_nettype wire

// ===== hw/rtl/klfs_led.sv =====
// Status LED control: hold timer, blink and feedback colours.
`default_nettype none
module klfs_led (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 step_i,
  input  wire logic [2:0]                           kind_i,
  input  wire logic [3:0]                           feedback_type_i,
  input  wire logic                                 enable_i,
  input  wire klfs_pkg::now_t                       now_i,
  output logic                                      led_wr_o,
  output logic [klfs_pkg::COLOR_WIDTH-1:0]          led_color_o
);

  logic [klfs_pkg::TIME_WIDTH-1:0]  start_q, start_d;
  logic                             timer_on_q, timer_on_d;
  logic [klfs_pkg::HOLD_WIDTH-1:0]  hold_q, hold_d;
  logic                             blink_q, blink_d;
  logic                             lit_q, lit_d;
  logic [klfs_pkg::COLOR_WIDTH-1:0] bcolor_q, bcolor_d;
  // Elapsed time since start, modulo the blink period
  logic [klfs_pkg::PHASE_WIDTH-1:0] phase_q, phase_d, phase_tick;
  logic [klfs_pkg::TIME_WIDTH-1:0]  elapsed;
  logic                             lit_now;

  // Elapsed time on a tick and its phase
  always_comb begin
    elapsed = now_i.ms - start_q;
    if (elapsed == '0) begin
      phase_tick = '0;
    end else if (phase_q == klfs_pkg::PHASE_LAST) begin
      phase_tick = '0;
    end else begin
      phase_tick = phase_q + klfs_pkg::PHASE_WIDTH'(1);
    end
    lit_now = (phase_tick <= klfs_pkg::PHASE_PULSE);
  end

  // Apply the transaction to the LED state
  always_comb begin
    start_d     = start_q;
    timer_on_d  = timer_on_q;
    hold_d      = hold_q;
    blink_d     = blink_q;
    lit_d       = lit_q;
    bcolor_d    = bcolor_q;
    phase_d     = phase_q;
    led_wr_o    = 1'b0;
    led_color_o = klfs_pkg::COLOR_BLACK;
    if (step_i) begin
      case (kind_i)
        klfs_pkg::KIND_TICK: begin
          phase_d = phase_tick;
          if (timer_on_q && (elapsed >= klfs_pkg::TIME_WIDTH'(hold_q))) begin
            // Hold time over: switch off as for the off event
            led_wr_o   = 1'b1;
            start_d    = '0;
            timer_on_d = 1'b0;
            hold_d     = '0;
            blink_d    = 1'b0;
            lit_d      = 1'b0;
            bcolor_d   = klfs_pkg::COLOR_BLACK;
            phase_d    = now_i.ms_mod;
          end else if (blink_q && (lit_now != lit_q)) begin
            lit_d       = lit_now;
            led_wr_o    = 1'b1;
            led_color_o = lit_now ? bcolor_q : klfs_pkg::COLOR_BLACK;
          end
        end
        klfs_pkg::KIND_FEEDBACK: begin
          if (enable_i) begin
            led_wr_o = 1'b1;
            case (feedback_type_i)
              klfs_pkg::FB_KEYPRESS: begin
                led_color_o = klfs_pkg::COLOR_BLUE;
                start_d     = now_i.ms;
                timer_on_d  = 1'b1;
                hold_d      = klfs_pkg::HOLD_SHORT;
                phase_d     = '0;
              end
              klfs_pkg::FB_OK, klfs_pkg::FB_ACTION_OK: begin
                led_color_o = klfs_pkg::COLOR_GREEN;
                start_d     = now_i.ms;
                timer_on_d  = 1'b1;
                hold_d      = klfs_pkg::HOLD_LONG;
                phase_d     = '0;
              end
              klfs_pkg::FB_NOT_FOUND: begin
                led_color_o = klfs_pkg::COLOR_ORANGE;
                start_d     = now_i.ms;
                timer_on_d  = 1'b1;
                hold_d      = klfs_pkg::HOLD_LONG;
                phase_d     = '0;
              end
              klfs_pkg::FB_FAILED, klfs_pkg::FB_UNKNOWN, klfs_pkg::FB_PAUSE_EXC: begin
                led_color_o = klfs_pkg::COLOR_RED;
                start_d     = now_i.ms;
                timer_on_d  = 1'b1;
                hold_d      = klfs_pkg::HOLD_LONG;
                phase_d     = '0;
              end
              klfs_pkg::FB_DELETED: begin
                // Timed blink, phase counted from now
                led_color_o = klfs_pkg::COLOR_RED;
                start_d     = now_i.ms;
                timer_on_d  = 1'b1;
                hold_d      = klfs_pkg::HOLD_LONG;
                blink_d     = 1'b1;
                bcolor_d    = klfs_pkg::COLOR_RED;
                phase_d     = '0;
              end
              klfs_pkg::FB_WAIT: begin
                // Endless blink, phase counted from time zero
                led_color_o = klfs_pkg::COLOR_BLUE;
                start_d     = '0;
                timer_on_d  = 1'b0;
                blink_d     = 1'b1;
                bcolor_d    = klfs_pkg::COLOR_BLUE;
                phase_d     = now_i.ms_mod;
              end
              klfs_pkg::FB_BUTTON: begin
                led_color_o = klfs_pkg::COLOR_WHITE;
                start_d     = '0;
                timer_on_d  = 1'b0;
                hold_d      = '0;
                phase_d     = now_i.ms_mod;
              end
              default: begin
                // Off and undefined types: black, drop any blink
                start_d    = '0;
                timer_on_d = 1'b0;
                hold_d     = '0;
                blink_d    = 1'b0;
                lit_d      = 1'b0;
                bcolor_d   = klfs_pkg::COLOR_BLACK;
                phase_d    = now_i.ms_mod;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      timer_on_q <= 1'b0;
      hold_q     <= '0;
      blink_q    <= 1'b0;
      lit_q      <= 1'b0;
      bcolor_q   <= klfs_pkg::COLOR_BLACK;
      phase_q    <= '0;
    end else begin
      start_q    <= start_d;
      timer_on_q <= timer_on_d;
      hold_q     <= hold_d;
      blink_q    <= blink_d;
      lit_q      <= lit_d;
      bcolor_q   <= bcolor_d;
      phase_q    <= phase_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/klfs_bl.sv =====
// Backlight control: level selection and off timeout.
`default_nettype none
module klfs_bl (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 step_i,
  input  wire logic [2:0]                           kind_i,
  input  wire logic [klfs_pkg::LEVEL_WIDTH-1:0]     bus_intensity_i,
  input  wire klfs_pkg::cfg_t                       cfg_i,
  input  wire klfs_pkg::now_t                       now_i,
  output logic                                      bl_wr_o,
  output logic [klfs_pkg::LEVEL_WIDTH-1:0]          bl_level_o,
  output logic                                      bl_on_o
);

  logic                            lit_q, lit_d;
  logic [klfs_pkg::TIME_WIDTH-1:0] start_q, start_d;
  logic                            timer_on_q, timer_on_d;
  logic [klfs_pkg::TIME_WIDTH-1:0] elapsed;
  logic [klfs_pkg::LEVEL_WIDTH-1:0] on_level;
  logic                            expired;

  // Select the on level from the mode
  always_comb begin
    case (cfg_i.backlight_level_mode)
      klfs_pkg::LVL_MODE_HIGH: on_level = klfs_pkg::LEVEL_HIGH;
      klfs_pkg::LVL_MODE_MED:  on_level = klfs_pkg::LEVEL_MED;
      klfs_pkg::LVL_MODE_LOW:  on_level = klfs_pkg::LEVEL_LOW;
      klfs_pkg::LVL_MODE_BUS:  on_level = bus_intensity_i;
      default:                 on_level = klfs_pkg::LEVEL_OFF;
    endcase
  end

  // Timeout check on a tick
  always_comb begin
    elapsed = now_i.ms - start_q;
    expired = timer_on_q && (cfg_i.backlight_delay_ms != '0) &&
              (elapsed >= klfs_pkg::TIME_WIDTH'(cfg_i.backlight_delay_ms));
  end

  // Apply the transaction to the backlight state
  always_comb begin
    lit_d      = lit_q;
    start_d    = start_q;
    timer_on_d = timer_on_q;
    bl_wr_o    = 1'b0;
    bl_level_o = klfs_pkg::LEVEL_OFF;
    if (step_i) begin
      case (kind_i)
        klfs_pkg::KIND_TICK: begin
          if (expired) begin
            bl_wr_o    = 1'b1;
            lit_d      = 1'b0;
            start_d    = '0;
            timer_on_d = 1'b0;
          end
        end
        klfs_pkg::KIND_BL_ON: begin
          bl_wr_o    = 1'b1;
          bl_level_o = on_level;
          lit_d      = 1'b1;
          start_d    = now_i.ms;
          timer_on_d = !cfg_i.backlight_always_on;
        end
        klfs_pkg::KIND_BL_OFF: begin
          bl_wr_o    = 1'b1;
          lit_d      = 1'b0;
          start_d    = '0;
          timer_on_d = 1'b0;
        end
        klfs_pkg::KIND_INIT: begin
          bl_wr_o    = 1'b1;
          timer_on_d = 1'b0;
          if (cfg_i.backlight_always_on) begin
            bl_level_o = on_level;
            lit_d      = 1'b1;
            start_d    = now_i.ms;
          end else begin
            lit_d      = 1'b0;
            start_d    = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q      <= 1'b0;
      start_q    <= '0;
      timer_on_q <= 1'b0;
    end else begin
      lit_q      <= lit_d;
      start_q    <= start_d;
      timer_on_q <= timer_on_d;
    end
  end

  assign bl_on_o = lit_d;

endmodule
`default_nettype wire
